// ===== rtl/cabf_pkg.sv =====
// ----------------------------------------------------------------------------
// cabf_pkg
// Types, constants and small helpers for the cosine angle-bend force unit.
// ----------------------------------------------------------------------------
package cabf_pkg;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
  localparam logic signed [47:0] SAT48_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT48_MIN   = 48'sh8000_0000_0000;

  typedef struct packed {
    logic               sweep_start;
    logic signed [31:0] sep0_x;
    logic signed [31:0] sep0_y;
    logic signed [31:0] sep0_z;
    logic signed [31:0] sep1_x;
    logic signed [31:0] sep1_y;
    logic signed [31:0] sep1_z;
  } item_t;

  typedef struct packed {
    logic signed [47:0] force0_x;
    logic signed [47:0] force0_y;
    logic signed [47:0] force0_z;
    logic signed [47:0] force1_x;
    logic signed [47:0] force1_y;
    logic signed [47:0] force1_z;
    logic signed [31:0] cosine_out;
    logic signed [47:0] energy_total;
    logic signed [31:0] cosine_lowest;
    logic signed [31:0] cosine_highest;
    logic               degenerate;
  } result_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // product scaled down by 2^30, rounded toward zero
  function automatic logic signed [35:0] trunc_q30(input logic signed [65:0] p);
    logic [65:0] pm;
    logic [35:0] t;
    pm = p[65] ? 66'(-p) : 66'(p);
    t  = pm[65:30];
    return p[65] ? -$signed(t) : $signed(t);
  endfunction

endpackage

// ===== rtl/cabf_item_if.sv =====
// ----------------------------------------------------------------------------
// cabf_item_if
// Valid/ready channel carrying one angle triple (two bond separations).
// ----------------------------------------------------------------------------
interface cabf_item_if import cabf_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cabf_result_if.sv =====
// ----------------------------------------------------------------------------
// cabf_result_if
// Valid/ready channel carrying forces, cosine and sweep statistics.
// ----------------------------------------------------------------------------
interface cabf_result_if import cabf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cosine_angle_bend_force.sv =====
// ----------------------------------------------------------------------------
// cosine_angle_bend_force
// Forces, cosine and sweep statistics for a cosine angle-bending potential.
// ----------------------------------------------------------------------------
// Usage:
//   bend   : one word per angle, the two Q16.16 separations from the central
//            particle plus a sweep-start flag that restarts the statistics.
//   result : one word per angle, forces on both end particles (Q32.16), the
//            cosine (Q2.30), running energy and cosine min/max.
//   kappa_we/kappa_wdata : stiffness write, only while the block is idle.
// Timing: an angle runs through one shared 64-bit subtract/compare unit and
//   one 33x33 multiplier under a sequencer; bend.ready is high only in idle.
//   A regular angle runs two normalize scans, two square roots and thirteen
//   restoring divides (twelve when the cosine saturates) at one quotient bit
//   per cycle (quotient bits: cosine 30, unit vectors 31, forces 34 to 49).
//   A zero-length bond goes straight from idle to the final step.
// The finished word sits in an output register; a new angle is taken while
//   it waits. If the receiver stalls past the next angle, the block holds in
//   its final step until the register frees.
// Reset (synchronous, rst high): kappa 0, energy 0, min +1, max -1, idle.
// ----------------------------------------------------------------------------
module cosine_angle_bend_force import cabf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               kappa_we,
  input  logic signed [31:0] kappa_wdata,
  cabf_item_if.sink          bend,
  cabf_result_if.source      result
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_NMAX   = 5'd1;
  localparam logic [4:0] ST_NSCAN  = 5'd2;
  localparam logic [4:0] ST_NAPPLY = 5'd3;
  localparam logic [4:0] ST_SQ     = 5'd4;
  localparam logic [4:0] ST_SQRT   = 5'd5;
  localparam logic [4:0] ST_DMUL   = 5'd6;
  localparam logic [4:0] ST_CCHK   = 5'd7;
  localparam logic [4:0] ST_DIV    = 5'd8;
  localparam logic [4:0] ST_CEND   = 5'd9;
  localparam logic [4:0] ST_USET   = 5'd10;
  localparam logic [4:0] ST_UEND   = 5'd11;
  localparam logic [4:0] ST_GTERM  = 5'd12;
  localparam logic [4:0] ST_KG     = 5'd13;
  localparam logic [4:0] ST_FSET   = 5'd14;
  localparam logic [4:0] ST_FEND   = 5'd15;
  localparam logic [4:0] ST_ENERGY = 5'd16;
  localparam logic [4:0] ST_DONE   = 5'd17;

  logic [4:0]         state, ret;
  logic signed [31:0] kappa;
  logic signed [47:0] energy_acc;
  logic signed [31:0] cos_min_reg, cos_max_reg;

  logic signed [31:0] sep0 [3];
  logic signed [31:0] sep1 [3];
  logic               degen;
  logic               vsel;
  logic [1:0]         idx;
  logic [31:0]        mx;
  logic signed [5:0]  shamt, s0, s1;
  logic signed [30:0] n0 [3];
  logic signed [30:0] n1 [3];
  logic [61:0]        q0, q1, dd;
  logic signed [63:0] dot;
  logic [63:0]        sq_x, sq_r;
  logic [4:0]         sq_k;
  logic [30:0]        m0, m1;
  logic [63:0]        dv_rem, dv_feed, dv_d;
  logic [49:0]        dv_q;
  logic [5:0]         cnt;
  logic signed [31:0] cosv;
  logic signed [31:0] u0 [3];
  logic signed [31:0] u1 [3];
  logic signed [32:0] g;
  logic signed [63:0] fp;
  logic signed [47:0] f0 [3];
  logic signed [47:0] f1 [3];

  // shared arithmetic
  logic [63:0]        sub_a, sub_b;
  logic [64:0]        sub_d;
  logic               sub_ge;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // helpers
  logic               in_degen, accept, last_pair;
  logic signed [31:0] vc [3];
  logic [31:0]        vm [3];
  logic [31:0]        vmax01, vmax;
  logic signed [31:0] cur_c;
  logic [31:0]        shl_v, shr_v;
  logic signed [30:0] napply;
  logic [63:0]        sq_bit, dot_mag, div_t, fp_mag;
  logic signed [30:0] n_cur;
  logic [30:0]        n_mag, m_cur;
  logic signed [5:0]  s_cur, fe;
  logic [4:0]         neg_amt;
  logic [49:0]        fq;
  logic signed [47:0] fval;
  logic signed [35:0] tq;
  logic signed [48:0] esum;
  logic signed [47:0] e_next;
  result_t            word;

  assign bend.ready = (state == ST_IDLE);
  assign accept     = bend.valid && bend.ready;
  assign in_degen   = (bend.data.sep0_x == 0 && bend.data.sep0_y == 0 &&
                       bend.data.sep0_z == 0) ||
                      (bend.data.sep1_x == 0 && bend.data.sep1_y == 0 &&
                       bend.data.sep1_z == 0);
  assign last_pair  = (idx == 2'd2) && vsel;

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_d[64];
  assign mul_p  = mul_a * mul_b;

  assign sq_bit  = 64'd1 << {sq_k, 1'b0};
  assign dot_mag = dot[63] ? 64'(-dot) : 64'(dot);
  assign div_t   = {dv_rem[62:0], dv_feed[63]};
  assign fp_mag  = fp[63] ? 64'(-fp) : 64'(fp);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vc[i] = vsel ? sep1[i] : sep0[i];
      vm[i] = mag32(vc[i]);
    end
    vmax01 = (vm[1] > vm[0]) ? vm[1] : vm[0];
    vmax   = (vm[2] > vmax01) ? vm[2] : vmax01;
    cur_c  = vc[idx];
    shl_v  = cur_c <<< shamt[4:0];
    shr_v  = mag32(cur_c) >> 5'(-shamt);
    if (!shamt[5]) begin
      napply = shl_v[30:0];
    end else begin
      napply = cur_c[31] ? -$signed(shr_v[30:0]) : $signed(shr_v[30:0]);
    end
    n_cur   = vsel ? n1[idx] : n0[idx];
    n_mag   = n_cur[30] ? 31'(-n_cur) : 31'(n_cur);
    m_cur   = vsel ? m1 : m0;
    s_cur   = vsel ? s1 : s0;
    fe      = s_cur - 6'sd14;
    neg_amt = 5'(-fe);
    fq      = fe[5] ? (dv_q >> neg_amt) : dv_q;
    if (fq[49:47] != 3'd0) begin
      fval = fp[63] ? SAT48_MIN : SAT48_MAX;
    end else begin
      fval = fp[63] ? -$signed({1'b0, fq[46:0]}) : $signed({1'b0, fq[46:0]});
    end
    tq     = trunc_q30(mul_p);
    esum   = 49'(energy_acc) + 49'(tq);
    if (esum[48] != esum[47]) begin
      e_next = esum[48] ? SAT48_MIN : SAT48_MAX;
    end else begin
      e_next = esum[47:0];
    end
  end

  // operand selection for the shared units
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQRT: begin
        sub_a = sq_x;
        sub_b = sq_r + sq_bit;
      end
      ST_CCHK: begin
        sub_a = dot_mag;
        sub_b = {2'b00, dd};
      end
      ST_DIV: begin
        sub_a = div_t;
        sub_b = dv_d;
      end
      ST_SQ: begin
        mul_a = (cnt[1:0] == 2'd1) ? 33'(n1[idx]) : 33'(n0[idx]);
        mul_b = (cnt[1:0] == 2'd0) ? 33'(n0[idx]) : 33'(n1[idx]);
      end
      ST_DMUL: begin
        mul_a = {2'b00, m0};
        mul_b = {2'b00, m1};
      end
      ST_GTERM: begin
        mul_a = 33'(cosv);
        mul_b = vsel ? 33'(u1[idx]) : 33'(u0[idx]);
      end
      ST_KG: begin
        mul_a = 33'(kappa);
        mul_b = g;
      end
      ST_ENERGY: begin
        mul_a = 33'(kappa);
        mul_b = 33'(cosv);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    word.force0_x       = degen ? '0 : f0[0];
    word.force0_y       = degen ? '0 : f0[1];
    word.force0_z       = degen ? '0 : f0[2];
    word.force1_x       = degen ? '0 : f1[0];
    word.force1_y       = degen ? '0 : f1[1];
    word.force1_z       = degen ? '0 : f1[2];
    word.cosine_out     = cosv;
    word.energy_total   = energy_acc;
    word.cosine_lowest  = cos_min_reg;
    word.cosine_highest = cos_max_reg;
    word.degenerate     = degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      kappa        <= '0;
      energy_acc   <= '0;
      cos_min_reg  <= ONE_Q30;
      cos_max_reg  <= NEG_ONE_Q30;
      result.valid <= 1'b0;
    end else begin
      if (kappa_we) begin
        kappa <= kappa_wdata;
      end
      // the final step handles valid itself
      if (result.valid && result.ready && state != ST_DONE) begin
        result.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            sep0[0] <= bend.data.sep0_x;
            sep0[1] <= bend.data.sep0_y;
            sep0[2] <= bend.data.sep0_z;
            sep1[0] <= bend.data.sep1_x;
            sep1[1] <= bend.data.sep1_y;
            sep1[2] <= bend.data.sep1_z;
            if (bend.data.sweep_start) begin
              energy_acc  <= '0;
              cos_min_reg <= ONE_Q30;
              cos_max_reg <= NEG_ONE_Q30;
            end
            degen <= in_degen;
            cosv  <= '0;
            vsel  <= 1'b0;
            state <= in_degen ? ST_DONE : ST_NMAX;
          end
        end

        ST_NMAX: begin
          mx    <= vmax;
          shamt <= '0;
          state <= ST_NSCAN;
        end

        // one bit of normalization per cycle
        ST_NSCAN: begin
          if (mx[31:29] == 3'd0) begin
            mx    <= mx << 1;
            shamt <= shamt + 6'sd1;
          end else if (mx[31:30] != 2'd0) begin
            mx    <= mx >> 1;
            shamt <= shamt - 6'sd1;
          end else begin
            idx   <= '0;
            state <= ST_NAPPLY;
          end
        end

        ST_NAPPLY: begin
          if (vsel) begin
            n1[idx] <= napply;
          end else begin
            n0[idx] <= napply;
          end
          if (idx == 2'd2) begin
            if (!vsel) begin
              s0    <= shamt;
              vsel  <= 1'b1;
              state <= ST_NMAX;
            end else begin
              s1    <= shamt;
              idx   <= '0;
              cnt   <= '0;
              q0    <= '0;
              q1    <= '0;
              dot   <= '0;
              state <= ST_SQ;
            end
          end else begin
            idx <= idx + 2'd1;
          end
        end

        // squares and dot product, one product per cycle
        ST_SQ: begin
          case (cnt[1:0])
            2'd0:    q0  <= q0 + mul_p[61:0];
            2'd1:    q1  <= q1 + mul_p[61:0];
            default: dot <= dot + mul_p[63:0];
          endcase
          if (cnt[1:0] == 2'd2) begin
            cnt <= '0;
            if (idx == 2'd2) begin
              vsel  <= 1'b0;
              sq_x  <= {2'b00, q0};
              sq_r  <= '0;
              sq_k  <= 5'd31;
              state <= ST_SQRT;
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end

        // digit-by-digit square root, one result bit per cycle
        ST_SQRT: begin
          logic [63:0] r_next;
          r_next = sub_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
          sq_r <= r_next;
          if (sub_ge) begin
            sq_x <= sub_d[63:0];
          end
          if (sq_k == 5'd0) begin
            if (!vsel) begin
              m0   <= r_next[30:0];
              vsel <= 1'b1;
              sq_x <= {2'b00, q1};
              sq_r <= '0;
              sq_k <= 5'd31;
            end else begin
              m1    <= r_next[30:0];
              state <= ST_DMUL;
            end
          end else begin
            sq_k <= sq_k - 5'd1;
          end
        end

        ST_DMUL: begin
          dd    <= mul_p[61:0];
          state <= ST_CCHK;
        end

        ST_CCHK: begin
          vsel <= 1'b0;
          idx  <= '0;
          if (sub_ge) begin
            cosv  <= dot[63] ? NEG_ONE_Q30 : ONE_Q30;
            state <= ST_USET;
          end else begin
            dv_rem  <= dot_mag;
            dv_feed <= '0;
            dv_d    <= {2'b00, dd};
            dv_q    <= '0;
            cnt     <= 6'd30;
            ret     <= ST_CEND;
            state   <= ST_DIV;
          end
        end

        // restoring divide, one quotient bit per cycle
        ST_DIV: begin
          if (sub_ge) begin
            dv_rem <= sub_d[63:0];
          end else begin
            dv_rem <= div_t;
          end
          dv_q    <= {dv_q[48:0], sub_ge};
          dv_feed <= dv_feed << 1;
          cnt     <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= ret;
          end
        end

        ST_CEND: begin
          cosv  <= dot[63] ? -$signed(dv_q[31:0]) : $signed(dv_q[31:0]);
          state <= ST_USET;
        end

        ST_USET: begin
          dv_rem  <= {34'd0, n_mag[30:1]};
          dv_feed <= {n_mag[0], 63'd0};
          dv_d    <= {33'd0, m_cur};
          dv_q    <= '0;
          cnt     <= 6'd31;
          ret     <= ST_UEND;
          state   <= ST_DIV;
        end

        ST_UEND: begin
          if (vsel) begin
            u1[idx] <= n_cur[30] ? -$signed(dv_q[31:0]) : $signed(dv_q[31:0]);
          end else begin
            u0[idx] <= n_cur[30] ? -$signed(dv_q[31:0]) : $signed(dv_q[31:0]);
          end
          vsel <= !vsel;
          if (vsel) begin
            idx <= last_pair ? 2'd0 : idx + 2'd1;
          end
          state <= last_pair ? ST_GTERM : ST_USET;
        end

        ST_GTERM: begin
          g <= 33'(tq) - (vsel ? 33'(u0[idx]) : 33'(u1[idx]));
          state <= ST_KG;
        end

        ST_KG: begin
          fp    <= mul_p[63:0];
          state <= ST_FSET;
        end

        ST_FSET: begin
          dv_rem  <= {34'd0, fp_mag[63:34]};
          dv_feed <= {fp_mag[33:0], 30'd0};
          dv_d    <= {33'd0, m_cur};
          dv_q    <= '0;
          cnt     <= fe[5] ? 6'd34 : 6'd34 + 6'(fe);
          ret     <= ST_FEND;
          state   <= ST_DIV;
        end

        ST_FEND: begin
          if (vsel) begin
            f1[idx] <= fval;
          end else begin
            f0[idx] <= fval;
          end
          vsel <= !vsel;
          if (vsel) begin
            idx <= last_pair ? 2'd0 : idx + 2'd1;
          end
          state <= last_pair ? ST_ENERGY : ST_GTERM;
        end

        ST_ENERGY: begin
          energy_acc <= e_next;
          if (cosv < cos_min_reg) begin
            cos_min_reg <= cosv;
          end
          if (cosv > cos_max_reg) begin
            cos_max_reg <= cosv;
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (!result.valid || result.ready) begin
            result.data  <= word;
            result.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a new word only appears when the sequencer leaves its final step
  a_word_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_DONE)
    else $error("result word raised outside final step");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt != 6'd0)
    else $error("divider running with zero step count");

  a_stats_range: assert property (@(posedge clk) disable iff (rst)
    cos_min_reg <= ONE_Q30 && cos_min_reg >= NEG_ONE_Q30 &&
    cos_max_reg <= ONE_Q30 && cos_max_reg >= NEG_ONE_Q30)
    else $error("cosine statistics out of range");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.degenerate |->
      result.data.cosine_out == 0 && result.data.force0_x == 0)
    else $error("degenerate word carries nonzero values");

endmodule
